// ===== src/epba_pkg.sv =====
// Package for the ephemeral port bitmap allocator.
// Holds the sequencer state type, the operation codes and the port width.
// Depends on nothing.
`default_nettype none

package epba_pkg;

    localparam int PORT_W = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BITS,
        ST_DIV,
        ST_FREE_RD,
        ST_FREE_WR
    } epba_state_t;

endpackage

`default_nettype wire

// ===== src/epba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the used-port bitmap; depends on nothing.
`default_nettype none

module epba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ephemeral_port_bitmap_allocator_core.sv =====
// Top level of the ephemeral port bitmap allocator: sequencer, datapath and bitmap RAM.
// Depends on epba_pkg and epba_ram.
//
// A transaction is accepted at a rising edge with start high and busy low. An allocate
// (op = 0) scans the bitmap one word per cycle through the RAM read port, skips full
// words, then walks the chosen word one bit per cycle to its lowest free bit, sets it
// and returns that port with ok high; with every port in use it returns port 0 and ok
// low. A free (op = 1) splits the port offset into word and bit with a reciprocal
// multiplication by the word width, then reads and rewrites the word; a word never
// written is neither read nor rewritten. A free below the base raises done with ok low
// and never raises busy. busy is high while a transaction is worked on and falls as
// done rises, so the next transaction is accepted at the earliest at the edge that
// ends the result cycle. Results appear on allocated_port and ok for the single cycle
// in which done is high, and the receiver cannot stall them. Reset marks every port
// free at once: a high-water mark of written words makes unwritten words read as zero,
// so there is no clearing pass and the block is ready as soon as reset is released.
`default_nettype none

module ephemeral_port_bitmap_allocator_core
    import epba_pkg::*;
#(
    parameter int PORT_BASE = 49152,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              op,
    input  wire logic [PORT_W-1:0] freed_port,
    output logic                   done,
    output logic      [PORT_W-1:0] allocated_port,
    output logic                   ok
);

    localparam int PORT_SPAN = 65536 - PORT_BASE;
    localparam int MAP_DEPTH = (PORT_SPAN + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int FILL_W = $clog2(MAP_DEPTH + 1);
    localparam int BIT_W = $clog2(MAP_WORD_BITS);
    localparam int LAST_BITS = PORT_SPAN - (MAP_DEPTH - 1) * MAP_WORD_BITS;
    localparam logic [MAP_WORD_BITS-1:0] LAST_MASK = ~({MAP_WORD_BITS{1'b1}} << LAST_BITS);
    localparam logic [MAP_WORD_BITS-1:0] BIT_ONE = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1};
    localparam int DIV_SH = PORT_W + BIT_W;
    localparam logic [PORT_W:0] DIV_RECIP =
        (PORT_W+1)'((2 ** DIV_SH + MAP_WORD_BITS - 1) / MAP_WORD_BITS);

    epba_state_t state_reg, state_next;

    logic [FILL_W-1:0]        issue_k_reg, issue_k_next;
    logic                     chk_vld_reg, chk_vld_next;
    logic [FILL_W-1:0]        chk_k_reg, chk_k_next;
    logic [ADDR_W-1:0]        k_reg, k_next;
    logic [BIT_W-1:0]         b_reg, b_next;
    logic [MAP_WORD_BITS-1:0] word_reg, word_next;
    logic [MAP_WORD_BITS-1:0] scan_reg, scan_next;
    logic [PORT_W-1:0]        div_reg, div_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic                     done_reg, done_next;
    logic                     ok_reg, ok_next;
    logic [PORT_W-1:0]        port_reg, port_next;

    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [MAP_WORD_BITS-1:0] ram_wr_data;
    logic                     ram_rd_en;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [MAP_WORD_BITS-1:0] ram_rd_data;

    logic [MAP_WORD_BITS-1:0] chk_word;
    logic [MAP_WORD_BITS-1:0] chk_eff;
    logic                     chk_full;
    logic                     chk_last;
    logic [MAP_WORD_BITS-1:0] bit_onehot;
    logic [2*PORT_W:0]        quo_prod;
    logic [PORT_W-1:0]        rem_full;
    logic                     free_hit;
    logic [PORT_W:0]          port_sum;
    logic                     below_base;

    epba_ram #(
        .WIDTH(MAP_WORD_BITS),
        .DEPTH(MAP_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_map (
        .clk(clk),
        .wr_en(ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en(ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign chk_word = (chk_k_reg >= fill_reg) ? '0 : ram_rd_data;
    assign chk_last = (chk_k_reg == FILL_W'(MAP_DEPTH - 1));
    assign chk_eff = chk_word | ~(chk_last ? LAST_MASK : {MAP_WORD_BITS{1'b1}});
    assign chk_full = &chk_eff;
    assign bit_onehot = BIT_ONE << b_reg;
    assign quo_prod = (2*PORT_W+1)'(div_reg) * (2*PORT_W+1)'(DIV_RECIP);
    assign rem_full = div_reg - PORT_W'(k_reg) * PORT_W'(MAP_WORD_BITS);
    assign free_hit = (FILL_W'(k_reg) < fill_reg);
    assign port_sum = (PORT_W+1)'(PORT_BASE) + (PORT_W+1)'(k_reg) * (PORT_W+1)'(MAP_WORD_BITS)
                      + (PORT_W+1)'(b_reg);
    assign below_base = ({1'b0, freed_port} < (PORT_W+1)'(PORT_BASE));

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign ok = ok_reg;
    assign allocated_port = port_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (!below_base)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    if (!chk_full)
                    begin
                        state_next = ST_BITS;
                    end
                    else if (chk_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BITS:
            begin
                if (!scan_reg[0])
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                state_next = ST_FREE_RD;
            end
            ST_FREE_RD:
            begin
                state_next = free_hit ? ST_FREE_WR : ST_IDLE;
            end
            ST_FREE_WR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        issue_k_next = issue_k_reg;
        chk_vld_next = chk_vld_reg;
        chk_k_next = chk_k_reg;
        k_next = k_reg;
        b_next = b_reg;
        word_next = word_reg;
        scan_next = scan_reg;
        div_next = div_reg;
        fill_next = fill_reg;
        done_next = 1'b0;
        ok_next = ok_reg;
        port_next = port_reg;
        ram_wr_en = 1'b0;
        ram_wr_addr = k_reg;
        ram_wr_data = word_reg | bit_onehot;
        ram_rd_en = 1'b0;
        ram_rd_addr = issue_k_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    issue_k_next = '0;
                    chk_vld_next = 1'b0;
                    div_next = freed_port - PORT_W'(PORT_BASE);
                    b_next = '0;
                    if (op == OP_FREE && below_base)
                    begin
                        done_next = 1'b1;
                        ok_next = 1'b0;
                        port_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_rd_en = (issue_k_reg < FILL_W'(MAP_DEPTH));
                issue_k_next = ram_rd_en ? issue_k_reg + 1'b1 : issue_k_reg;
                chk_vld_next = ram_rd_en;
                chk_k_next = issue_k_reg;
                if (chk_vld_reg)
                begin
                    if (!chk_full)
                    begin
                        word_next = chk_word;
                        scan_next = chk_eff;
                        k_next = chk_k_reg[ADDR_W-1:0];
                        b_next = '0;
                    end
                    else if (chk_last)
                    begin
                        done_next = 1'b1;
                        ok_next = 1'b0;
                        port_next = '0;
                    end
                end
            end
            ST_BITS:
            begin
                if (!scan_reg[0])
                begin
                    ram_wr_en = 1'b1;
                    done_next = 1'b1;
                    ok_next = 1'b1;
                    port_next = port_sum[PORT_W-1:0];
                    if (FILL_W'(k_reg) >= fill_reg)
                    begin
                        fill_next = FILL_W'(k_reg) + 1'b1;
                    end
                end
                else
                begin
                    scan_next = scan_reg >> 1;
                    b_next = b_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                k_next = quo_prod[DIV_SH +: ADDR_W];
            end
            ST_FREE_RD:
            begin
                ram_rd_addr = k_reg;
                ram_rd_en = free_hit;
                b_next = rem_full[BIT_W-1:0];
                if (!free_hit)
                begin
                    done_next = 1'b1;
                    ok_next = 1'b1;
                    port_next = '0;
                end
            end
            ST_FREE_WR:
            begin
                ram_wr_en = 1'b1;
                ram_wr_addr = k_reg;
                ram_wr_data = ram_rd_data & ~bit_onehot;
                done_next = 1'b1;
                ok_next = 1'b1;
                port_next = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chk_vld_reg <= 1'b0;
            fill_reg <= '0;
            done_reg <= 1'b0;
            ok_reg <= 1'b0;
            port_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chk_vld_reg <= chk_vld_next;
            fill_reg <= fill_next;
            done_reg <= done_next;
            ok_reg <= ok_next;
            port_reg <= port_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_k_reg <= issue_k_next;
        chk_k_reg <= chk_k_next;
        k_reg <= k_next;
        b_reg <= b_next;
        word_reg <= word_next;
        scan_reg <= scan_next;
        div_reg <= div_next;
    end

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy || start))
        else $error("Result strobe without a transaction in progress.");

    a_fail_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !ok_reg) |-> (port_reg == '0))
        else $error("Failed transaction returned a nonzero port.");

    a_port_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && port_reg != '0) |-> ({1'b0, port_reg} >= (PORT_W+1)'(PORT_BASE)))
        else $error("Granted port lies below the ephemeral base.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAP_DEPTH))
        else $error("High-water mark beyond the bitmap depth.");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_BITS || state_reg == ST_FREE_WR) && state_next == ST_IDLE)
        else $error("Bitmap write outside a finishing step.");

endmodule

`default_nettype wire
